@@ rtl/wms_pkg.sv @@
// Package for the window MAD stability detector.
// Holds widths, reset values, request codes and the sequencer state type.
// No dependencies.
package wms_pkg;

  localparam int WINDOW_LEN_DEF = 8;
  localparam int SAMPLE_W       = 24;
  localparam int TOL_W          = 24;

  localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(256);

  localparam logic REQ_PUSH  = 1'b0;
  localparam logic REQ_CLEAR = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RANK,
    ST_RDRAIN,
    ST_MED,
    ST_DEV,
    ST_DDRAIN,
    ST_FINISH
  } state_t;

endpackage

@@ rtl/window_mad_stability_detector.sv @@
// A push that leaves the window full runs the sequencer through ranking, median, deviations,
// a second ranking and median before out_valid; any other item goes straight to finish.
// The input stalls until the previous item's result is loaded into the output register;
// the single comparator ranks every entry pair, for samples and for deviations.
// Reset (rst_n low, synchronous): pointer, fill count and sequencer cleared,
// tolerance back to 256; stored samples are kept and not cleared.
module window_mad_stability_detector #(
  parameter int WINDOW_LEN = wms_pkg::WINDOW_LEN_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr_en,
  input  logic [wms_pkg::TOL_W-1:0]           cfg_wr_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_req_type,
  input  logic signed [wms_pkg::SAMPLE_W-1:0] in_sample,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                out_window_full,
  output logic                                out_stable
);
  import wms_pkg::*;

  localparam int IW        = $clog2(WINDOW_LEN);
  localparam int FW        = $clog2(WINDOW_LEN + 1);
  localparam int DW        = SAMPLE_W + 3;
  localparam int MW        = DW + 1;
  localparam int MEM_DEPTH = 2 ** (IW + 1);

  localparam logic [IW-1:0] LAST   = IW'(WINDOW_LEN - 1);
  localparam logic [IW-1:0] MID_LO = IW'((WINDOW_LEN - 1) / 2);
  localparam logic [IW-1:0] MID_HI = IW'(WINDOW_LEN / 2);
  localparam logic [FW-1:0] FULL   = FW'(WINDOW_LEN);

  // bank 0: samples, bank 1: absolute deviations
  logic signed [DW-1:0] work_mem [MEM_DEPTH];

  state_t               state_r, state_nxt;
  logic [IW-1:0]        i_r, i_nxt, j_r, j_nxt;
  logic                 bank_r, bank_nxt;
  logic [IW-1:0]        ptr_r, ptr_nxt;
  logic [FW-1:0]        fill_r, fill_nxt;
  logic [TOL_W-1:0]     tol_r;

  logic                 pv_r, plast_r;
  logic [IW-1:0]        pi_r, pj_r;
  logic signed [DW-1:0] rd_a_r, rd_b_r;
  logic [IW-1:0]        cnt_r;
  logic signed [DW-1:0] lo_r, hi_r;
  logic signed [MW-1:0] med2_r;
  logic                 full_res_r, stable_res_r;
  logic                 out_valid_r, out_full_r, out_stable_r;

  logic                 in_acc, ld_out, iss_v, iss_last;
  logic                 less;
  logic [IW-1:0]        cnt_nxt;
  logic signed [MW-1:0] mid_sum, two_x, diff;
  logic signed [DW-1:0] dev_val;
  logic [IW:0]          addr_a, addr_b, wr_addr;
  logic                 wr_en;
  logic signed [DW-1:0] wr_data;
  logic                 rank_phase, dev_phase;

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign ld_out   = (state_r == ST_FINISH) && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt = state_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    bank_nxt  = bank_r;
    ptr_nxt   = ptr_r;
    fill_nxt  = fill_r;
    iss_v     = 1'b0;
    iss_last  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_req_type == REQ_CLEAR) begin
            ptr_nxt  = '0;
            fill_nxt = '0;
          end else begin
            ptr_nxt  = (ptr_r == LAST) ? '0 : ptr_r + 1'b1;
            fill_nxt = (fill_r == FULL) ? fill_r : fill_r + 1'b1;
          end
          i_nxt     = '0;
          j_nxt     = '0;
          bank_nxt  = 1'b0;
          state_nxt = (fill_nxt == FULL) ? ST_RANK : ST_FINISH;
        end
      end
      ST_RANK: begin
        iss_v    = 1'b1;
        iss_last = (j_r == LAST);
        if (j_r == LAST) begin
          j_nxt = '0;
          if (i_r == LAST) begin
            i_nxt     = '0;
            state_nxt = ST_RDRAIN;
          end else begin
            i_nxt = i_r + 1'b1;
          end
        end else begin
          j_nxt = j_r + 1'b1;
        end
      end
      ST_RDRAIN: state_nxt = ST_MED;
      ST_MED: begin
        i_nxt     = '0;
        j_nxt     = '0;
        state_nxt = bank_r ? ST_FINISH : ST_DEV;
      end
      ST_DEV: begin
        iss_v = 1'b1;
        if (i_r == LAST) begin
          i_nxt     = '0;
          state_nxt = ST_DDRAIN;
        end else begin
          i_nxt = i_r + 1'b1;
        end
      end
      ST_DDRAIN: begin
        bank_nxt  = 1'b1;
        state_nxt = ST_RANK;
      end
      ST_FINISH: begin
        if (ld_out) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      i_r     <= '0;
      j_r     <= '0;
      bank_r  <= 1'b0;
      ptr_r   <= '0;
      fill_r  <= '0;
      pv_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      bank_r  <= bank_nxt;
      ptr_r   <= ptr_nxt;
      fill_r  <= fill_nxt;
      pv_r    <= iss_v;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= TOL_RESET;
    end else if (cfg_wr_en) begin
      tol_r <= cfg_wr_data;
    end
  end

  // Work memory: one write port, two registered read ports
  assign addr_a     = {bank_r, i_r};
  assign addr_b     = {bank_r, j_r};
  assign rank_phase = pv_r && (state_r == ST_RANK || state_r == ST_RDRAIN);
  assign dev_phase  = pv_r && (state_r == ST_DEV || state_r == ST_DDRAIN);

  assign two_x   = {rd_a_r, 1'b0};
  assign diff    = two_x - med2_r;
  assign dev_val = diff[MW-1] ? DW'(-diff) : DW'(diff);

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = {1'b0, ptr_r};
    wr_data = {{(DW-SAMPLE_W){in_sample[SAMPLE_W-1]}}, in_sample};
    if (in_acc && in_req_type == REQ_PUSH) begin
      wr_en = 1'b1;
    end else if (dev_phase) begin
      wr_en   = 1'b1;
      wr_addr = {1'b1, pi_r};
      wr_data = dev_val;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) work_mem[wr_addr] <= wr_data;
    rd_a_r <= work_mem[addr_a];
    rd_b_r <= work_mem[addr_b];
  end

  // Shared rank unit: counts entries that sort before entry i (ties by index)
  assign less    = (rd_b_r < rd_a_r) || ((rd_b_r == rd_a_r) && (pj_r < pi_r));
  assign cnt_nxt = ((pj_r == '0) ? '0 : cnt_r) + IW'(less);
  assign mid_sum = {lo_r[DW-1], lo_r} + {hi_r[DW-1], hi_r};

  always_ff @(posedge clk) begin
    pi_r    <= i_r;
    pj_r    <= j_r;
    plast_r <= iss_last;
    if (rank_phase) begin
      cnt_r <= cnt_nxt;
      if (plast_r && cnt_nxt == MID_LO) lo_r <= rd_a_r;
      if (plast_r && cnt_nxt == MID_HI) hi_r <= rd_a_r;
    end
    if (state_r == ST_MED) begin
      if (!bank_r) begin
        med2_r <= mid_sum;
      end else begin
        stable_res_r <= (mid_sum <= $signed({{(MW-TOL_W-1){1'b0}}, tol_r, 1'b0}));
      end
    end
    if (in_acc) begin
      full_res_r   <= (fill_nxt == FULL);
      stable_res_r <= 1'b0;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ld_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ld_out) begin
      out_full_r   <= full_res_r;
      out_stable_r <= stable_res_r && full_res_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_window_full = out_full_r;
  assign out_stable      = out_stable_r;

  a_rise_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_FINISH))
    else $error("result appeared without finishing an item");

  a_stable_needs_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (!out_stable_r || out_full_r))
    else $error("stable reported on a window that is not full");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FULL)
    else $error("fill count exceeds window length");

  a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r != ST_IDLE))
    else $error("sequencer stayed idle after an input transfer");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> (out_valid_r && $stable(out_stable_r)))
    else $error("pending result lost or changed");

endmodule

@@ sim/testbench.sv @@
// Testbench for window_mad_stability_detector: a directed table, then random bursts
// of clustered and noisy samples, checked against table expectations or a built-in median/MAD predictor.
// Depends on rtl/wms_pkg.sv and rtl/window_mad_stability_detector.sv.
module testbench;
  import wms_pkg::*;

  localparam int N = WINDOW_LEN_DEF;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int BATCHES = 9;
  localparam int BATCH_ITEMS = 76;
  localparam int DIR_ROWS = 19;

  typedef struct packed {
    logic full;
    logic stable;
  } status_t;

  typedef struct packed {
    logic                req;
    logic [SAMPLE_W-1:0] smp;
    logic                typed;
    status_t             want;
  } dir_row_t;

  typedef longint lane_t [N];

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       cfg_wr_en = 1'b0;
  logic [TOL_W-1:0]           cfg_wr_data = '0;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic                       in_req_type = REQ_PUSH;
  logic signed [SAMPLE_W-1:0] in_sample = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic                       out_window_full;
  logic                       out_stable;

  logic signed [SAMPLE_W-1:0] win_samples [N];
  int                         next_slot;
  int                         pushes_held;
  logic [TOL_W-1:0]           tol_model;

  status_t status_q [$];
  int      mismatch_cnt = 0;
  int      cycle_cnt = 0;
  int      items_sent = 0;
  int      snd_idle_pct = 0;
  int      rcv_stall_pct = 0;

  dir_row_t dir_rows [DIR_ROWS] = '{
    '{REQ_PUSH,  24'h800000, 1'b1, '{1'b0, 1'b0}},
    '{REQ_PUSH,  24'h7FFFFF, 1'b1, '{1'b0, 1'b0}},
    '{REQ_CLEAR, 24'hFFFFFF, 1'b1, '{1'b0, 1'b0}},
    '{REQ_PUSH,  24'h7FFFFF, 1'b1, '{1'b0, 1'b0}},
    '{REQ_PUSH,  24'h7FFFFF, 1'b1, '{1'b0, 1'b0}},
    '{REQ_PUSH,  24'h7FFFFF, 1'b1, '{1'b0, 1'b0}},
    '{REQ_PUSH,  24'h7FFFFF, 1'b1, '{1'b0, 1'b0}},
    '{REQ_PUSH,  24'h7FFFFF, 1'b1, '{1'b0, 1'b0}},
    '{REQ_PUSH,  24'h7FFFFF, 1'b1, '{1'b0, 1'b0}},
    '{REQ_PUSH,  24'h7FFFFF, 1'b1, '{1'b0, 1'b0}},
    '{REQ_PUSH,  24'h7FFFFF, 1'b1, '{1'b1, 1'b1}},
    '{REQ_PUSH,  24'h555555, 1'b0, '{1'b0, 1'b0}},
    '{REQ_PUSH,  24'hAAAAAA, 1'b0, '{1'b0, 1'b0}},
    '{REQ_PUSH,  24'h800000, 1'b0, '{1'b0, 1'b0}},
    '{REQ_PUSH,  24'h800000, 1'b0, '{1'b0, 1'b0}},
    '{REQ_CLEAR, 24'h000000, 1'b1, '{1'b0, 1'b0}},
    '{REQ_PUSH,  24'h000000, 1'b1, '{1'b0, 1'b0}},
    '{REQ_CLEAR, 24'h123456, 1'b1, '{1'b0, 1'b0}},
    '{REQ_PUSH,  24'h000001, 1'b1, '{1'b0, 1'b0}}
  };

  window_mad_stability_detector i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_req_type     (in_req_type),
    .in_sample       (in_sample),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_window_full (out_window_full),
    .out_stable      (out_stable)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic longint mid2_of(input lane_t v);
    longint key;
    int     j;
    for (int i = 1; i < N; i++) begin
      key = v[i];
      j = i;
      while (j > 0 && v[j-1] > key) begin
        v[j] = v[j-1];
        j--;
      end
      v[j] = key;
    end
    return (N % 2 == 0) ? v[N/2-1] + v[N/2] : 2 * v[N/2];
  endfunction

  function automatic logic judge_settled();
    lane_t  vals;
    lane_t  devs;
    longint m2;
    if (pushes_held < N) return 1'b0;
    foreach (vals[i]) vals[i] = longint'(win_samples[i]);
    m2 = mid2_of(vals);
    foreach (devs[i]) begin
      devs[i] = 2 * longint'(win_samples[i]) - m2;
      if (devs[i] < 0) devs[i] = -devs[i];
    end
    return mid2_of(devs) <= 2 * longint'(tol_model);
  endfunction

  function automatic status_t apply_request(input logic req, input logic [SAMPLE_W-1:0] smp);
    status_t r;
    if (req == REQ_CLEAR) begin
      next_slot = 0;
      pushes_held = 0;
    end else begin
      win_samples[next_slot] = smp;
      next_slot = (next_slot + 1) % N;
      if (pushes_held < N) pushes_held++;
    end
    r.full = (pushes_held == N);
    r.stable = judge_settled();
    return r;
  endfunction

  task automatic send_req(input logic req, input logic [SAMPLE_W-1:0] smp,
                          input logic typed, input status_t fixed);
    status_t pred;
    if ($urandom_range(99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req_type <= req;
    in_sample <= smp;
    do @(posedge clk); while (in_stall);
    pred = apply_request(req, smp);
    status_q.push_back(typed ? fixed : pred);
    items_sent++;
  endtask

  task automatic drain();
    if (in_valid) in_valid <= 1'b0;
    while (status_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_tol(input logic [TOL_W-1:0] v);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    tol_model = v;
  endtask

  // bursts of clustered pushes around a random level, with noise runs between them
  task automatic run_batch(input int target, input logic force_pause);
    int     run_len;
    int     center;
    int     spread;
    int     k;
    longint s;
    logic   paused;
    paused = 1'b0;
    while (items_sent < target) begin
      if ((force_pause && !paused && items_sent > target - BATCH_ITEMS / 2) ||
          $urandom_range(49) == 0) begin
        drain();
        paused = 1'b1;
      end
      if ($urandom_range(99) < 20) begin
        run_len = $urandom_range(1, 6);
        for (k = 0; k < run_len; k++)
          send_req(($urandom_range(9) == 0) ? REQ_CLEAR : REQ_PUSH, 24'($urandom), 1'b0, '0);
      end else begin
        if ($urandom_range(1) == 0) send_req(REQ_CLEAR, 24'($urandom), 1'b0, '0);
        center = $signed($urandom) >>> 8;
        case ($urandom_range(5))
          0: spread = 0;
          1: spread = $urandom_range(0, 3);
          5: spread = 1 << $urandom_range(0, 24);
          default: begin
            spread = int'((longint'(tol_model) * $urandom_range(1, 6)) / 2);
            spread = spread + $urandom_range(0, 3);
          end
        endcase
        if (spread > (1 << 24)) spread = 1 << 24;
        run_len = $urandom_range(N, 3 * N);
        for (k = 0; k < run_len; k++) begin
          s = longint'(center) + longint'($urandom_range(0, 2 * spread)) - spread;
          if (s > 8388607) s = 8388607;
          if (s < -8388608) s = -8388608;
          send_req(REQ_PUSH, 24'(s), 1'b0, '0);
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (status_q.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("unexpected transfer: full=%0b stable=%0b", out_window_full, out_stable);
        end else if (out_window_full !== status_q[0].full ||
                     out_stable !== status_q[0].stable) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("mismatch: expected full=%0b stable=%0b, got full=%0b stable=%0b",
                     status_q[0].full, status_q[0].stable, out_window_full, out_stable);
          void'(status_q.pop_front());
        end else begin
          void'(status_q.pop_front());
        end
      end
      out_stall <= ($urandom_range(99) < rcv_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    int               b;
    logic [TOL_W-1:0] tol_pick;
    foreach (win_samples[i]) win_samples[i] = '0;
    next_slot = 0;
    pushes_held = 0;
    tol_model = TOL_RESET;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    snd_idle_pct = 17;
    rcv_stall_pct = 71;
    for (int i = 0; i < DIR_ROWS; i++)
      send_req(dir_rows[i].req, dir_rows[i].smp, dir_rows[i].typed, dir_rows[i].want);

    for (b = 0; b < BATCHES; b++) begin
      drain();
      case (b / 3)
        0: begin
          snd_idle_pct = 17;
          rcv_stall_pct = 71;
        end
        1: begin
          snd_idle_pct = 71;
          rcv_stall_pct = 17;
        end
        default: begin
          snd_idle_pct = 0;
          rcv_stall_pct = 0;
        end
      endcase
      case (b)
        0: tol_pick = '0;
        1: tol_pick = '1;
        2: tol_pick = TOL_RESET;
        default: begin
          case ($urandom_range(3))
            0: tol_pick = TOL_W'($urandom_range(0, 15));
            1: tol_pick = TOL_W'($urandom_range(16, 4095));
            2: tol_pick = TOL_W'($urandom_range(4096, 1 << 20));
            default: tol_pick = 24'($urandom);
          endcase
        end
      endcase
      write_tol(tol_pick);
      run_batch(DIR_ROWS + (b + 1) * BATCH_ITEMS, b == 0);
    end

    drain();
    repeat (2 * N * N + N + 26) @(posedge clk);
    if (mismatch_cnt == 0 && status_q.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
